FILE: hw/rtl/sof_framed_command_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the start-of-frame command parser
// Shorthand for the concurrent checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SOF_FRAMED_COMMAND_PARSER_ASSERT_SVH
`define SOF_FRAMED_COMMAND_PARSER_ASSERT_SVH

// same-cycle implication, masked while reset is asserted
`define SFCP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is asserted
`define SFCP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sfcp_pkg.sv
// ----------------------------------------------------------------------------
// sfcp_pkg
// Types and constants shared by the start-of-frame command parser.
// ----------------------------------------------------------------------------
package sfcp_pkg;

    localparam int MAX_PAYLOAD_BYTES = 8;
    localparam int IDENT_BYTES       = 4;

    localparam int BYTE_W    = 8;
    localparam int IDENT_W   = 32;
    localparam int LEN_W     = 4;
    localparam int PAYLOAD_W = 64;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hAA;

    // frame phase, one-hot
    typedef enum logic [4:0] {
        PH_SOF  = 5'b00001,
        PH_CMD  = 5'b00010,
        PH_ID   = 5'b00100,
        PH_LEN  = 5'b01000,
        PH_DATA = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0]    frame_cmd;
        logic [IDENT_W-1:0]   frame_ident;
        logic [LEN_W-1:0]     frame_len;
        logic [PAYLOAD_W-1:0] frame_payload;
    } t_frame;

    // registered input word as seen by the parse core
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_word;

    // result handed from the parse core to the output register
    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_result;

endpackage

FILE: hw/rtl/sfcp_ifs.sv
// ----------------------------------------------------------------------------
// sfcp channel interfaces
// Valid/ready channels for received bytes, parsed frames and configuration.
// ----------------------------------------------------------------------------
interface sfcp_byte_if;
    logic                      valid;
    logic                      ready;
    logic [sfcp_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcp_frame_if;
    logic                          valid;
    logic                          ready;
    logic [sfcp_pkg::BYTE_W-1:0]    frame_cmd;
    logic [sfcp_pkg::IDENT_W-1:0]   frame_ident;
    logic [sfcp_pkg::LEN_W-1:0]     frame_len;
    logic [sfcp_pkg::PAYLOAD_W-1:0] frame_payload;

    modport source (output valid, output frame_cmd, output frame_ident,
                    output frame_len, output frame_payload, input ready);
    modport sink   (input valid, input frame_cmd, input frame_ident,
                    input frame_len, input frame_payload, output ready);
endinterface

interface sfcp_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sfcp_pkg::BYTE_W-1:0] start_byte;

    modport source (output valid, output start_byte, input ready);
    modport sink   (input valid, input start_byte, output ready);
endinterface

FILE: hw/rtl/sfcp_in_reg.sv
// ----------------------------------------------------------------------------
// sfcp_in_reg
// Input register: captures one received byte and holds it until parsed.
// ----------------------------------------------------------------------------
module sfcp_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sfcp_byte_if.sink          i_rx,
    input  logic               i_fire,
    output sfcp_pkg::t_in_word o_word
);
    import sfcp_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              w_load;

    assign i_rx.ready = !r_valid || i_fire;
    assign w_load     = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_word.valid   = r_valid;
    assign o_word.rx_byte = r_byte;

endmodule

FILE: hw/rtl/sfcp_parse_core.sv
// ----------------------------------------------------------------------------
// sfcp_parse_core
// Frame state machine: updates phase and holds for one byte per cycle; a frame-ending byte waits for output space.
// ----------------------------------------------------------------------------
module sfcp_parse_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sfcp_cfg_if.sink           i_cfg,
    input  sfcp_pkg::t_in_word i_word,
    input  logic               i_out_space,
    output logic               o_fire,
    output sfcp_pkg::t_result  o_res
);
    import sfcp_pkg::*;

    logic [BYTE_W-1:0]    r_start_byte;
    t_phase               r_phase,     n_phase;
    logic [BYTE_W-1:0]    r_cmd,       n_cmd;
    logic [IDENT_W-1:0]   r_ident,     n_ident;
    logic [2:0]           r_ident_cnt, n_ident_cnt;
    logic [LEN_W-1:0]     r_len,       n_len;
    logic [LEN_W-1:0]     r_data_idx,  n_data_idx;
    logic [PAYLOAD_W-1:0] r_payload,   n_payload;

    logic              w_is_start;
    logic [BYTE_W-1:0] w_b;
    t_result           w_res;

    assign i_cfg.ready = 1'b1;
    assign w_b         = i_word.rx_byte;
    assign w_is_start  = (w_b == r_start_byte);

    always_comb begin
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_ident     = r_ident;
        n_ident_cnt = r_ident_cnt;
        n_len       = r_len;
        n_data_idx  = r_data_idx;
        n_payload   = r_payload;
        w_res       = '0;

        if (w_is_start) begin
            // restart the frame from any phase
            n_phase     = PH_CMD;
            n_cmd       = '0;
            n_ident     = '0;
            n_ident_cnt = '0;
            n_len       = '0;
            n_data_idx  = '0;
            n_payload   = '0;
        end else begin
            case (r_phase)
                PH_CMD: begin
                    n_cmd   = w_b;
                    n_phase = PH_ID;
                end
                PH_ID: begin
                    for (int k = 0; k < IDENT_BYTES; k++) begin
                        if (r_ident_cnt[1:0] == 2'(k)) begin
                            n_ident[8*k +: 8] = r_ident[8*k +: 8] | w_b;
                        end
                    end
                    n_ident_cnt = r_ident_cnt + 3'd1;
                    if (n_ident_cnt >= 3'(IDENT_BYTES)) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (w_b > BYTE_W'(MAX_PAYLOAD_BYTES)) begin
                        // drop the frame, keep holds
                        n_phase = PH_SOF;
                    end else begin
                        n_len      = w_b[LEN_W-1:0];
                        n_data_idx = '0;
                        if (w_b[LEN_W-1:0] != '0) begin
                            n_phase = PH_DATA;
                        end else begin
                            n_phase                   = PH_SOF;
                            w_res.valid               = 1'b1;
                            w_res.frame.frame_cmd     = r_cmd;
                            w_res.frame.frame_ident   = r_ident;
                            w_res.frame.frame_len     = w_b[LEN_W-1:0];
                            w_res.frame.frame_payload = r_payload;
                        end
                    end
                end
                PH_DATA: begin
                    for (int k = 0; k < MAX_PAYLOAD_BYTES; k++) begin
                        if (r_data_idx[2:0] == 3'(k)) begin
                            n_payload[8*k +: 8] = r_payload[8*k +: 8] | w_b;
                        end
                    end
                    n_data_idx = r_data_idx + 4'd1;
                    if (n_data_idx >= r_len) begin
                        n_phase                   = PH_SOF;
                        w_res.valid               = 1'b1;
                        w_res.frame.frame_cmd     = r_cmd;
                        w_res.frame.frame_ident   = r_ident;
                        w_res.frame.frame_len     = r_len;
                        w_res.frame.frame_payload = n_payload;
                    end
                end
                default: begin
                    n_phase = PH_SOF;
                end
            endcase
        end

        w_res.valid = w_res.valid && i_word.valid;
    end

    // a word that yields no frame never waits on the output side
    assign o_fire = i_word.valid && (!w_res.valid || i_out_space);
    assign o_res  = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RESET;
        end else if (i_cfg.valid) begin
            r_start_byte <= i_cfg.start_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SOF;
            r_cmd       <= '0;
            r_ident     <= '0;
            r_ident_cnt <= '0;
            r_len       <= '0;
            r_data_idx  <= '0;
            r_payload   <= '0;
        end else if (o_fire) begin
            r_phase     <= n_phase;
            r_cmd       <= n_cmd;
            r_ident     <= n_ident;
            r_ident_cnt <= n_ident_cnt;
            r_len       <= n_len;
            r_data_idx  <= n_data_idx;
            r_payload   <= n_payload;
        end
    end

endmodule

FILE: hw/rtl/sfcp_out_reg.sv
// ----------------------------------------------------------------------------
// sfcp_out_reg
// Output register: holds one parsed frame until the sink takes it.
// ----------------------------------------------------------------------------
module sfcp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfcp_pkg::t_result i_res,
    input  logic              i_fire,
    output logic              o_space,
    sfcp_frame_if.source      o_frame
);
    import sfcp_pkg::*;

    logic   r_valid;
    t_frame r_frame;
    logic   w_load;

    assign o_space = !r_valid || o_frame.ready;
    assign w_load  = i_fire && i_res.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_frame <= i_res.frame;
        end
    end

    assign o_frame.valid         = r_valid;
    assign o_frame.frame_cmd     = r_frame.frame_cmd;
    assign o_frame.frame_ident   = r_frame.frame_ident;
    assign o_frame.frame_len     = r_frame.frame_len;
    assign o_frame.frame_payload = r_frame.frame_payload;

endmodule

FILE: hw/rtl/sof_framed_command_parser.sv
// ----------------------------------------------------------------------------
// sof_framed_command_parser
// Parses start-byte framed commands from a byte stream into frame words.
//
//   channel   dir   word
//   i_rx      in    rx_byte
//   o_frame   out   frame_cmd, frame_ident, frame_len, frame_payload
//   i_cfg     in    start_byte (always ready)
//
// One byte per cycle; a byte is parsed from the input register and its frame
// word is loaded into the output register at the edge on which the byte is consumed.
// Bytes that complete no frame never wait on o_frame; a byte that completes
// a frame waits in the input register only while o_frame holds a frame that
// is not taken. Reset returns to waiting for a start byte, start byte 0xAA.
// ----------------------------------------------------------------------------
`include "sof_framed_command_parser_assert.svh"

module sof_framed_command_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sfcp_byte_if.sink     i_rx,
    sfcp_cfg_if.sink      i_cfg,
    sfcp_frame_if.source  o_frame
);
    import sfcp_pkg::*;

    t_in_word w_word;
    t_result  w_res;
    logic     w_fire;
    logic     w_out_space;

    sfcp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_fire  (w_fire),
        .o_word  (w_word)
    );

    sfcp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_word      (w_word),
        .i_out_space (w_out_space),
        .o_fire      (w_fire),
        .o_res       (w_res)
    );

    sfcp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res),
        .i_fire  (w_fire),
        .o_space (w_out_space),
        .o_frame (o_frame)
    );

    `SFCP_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_fire && w_res.valid, w_out_space,
        "frame committed while output register is full")
    `SFCP_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, w_word.valid && !w_fire,
        w_word.valid && $stable(w_word.rx_byte), "pending input word lost")
    `SFCP_ASSERT_IMP(a_len_range, i_clk, i_rst_n, w_res.valid,
        w_res.frame.frame_len <= LEN_W'(MAX_PAYLOAD_BYTES), "frame length out of range")

endmodule
